// ===== rtl/core/assert_macros.svh =====
// assertion helpers, compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/q15mm_pkg.sv =====
package q15mm_pkg;

  typedef logic [1:0]         mode_t;
  typedef logic [3:0]         index_t;
  typedef logic signed [15:0] q15_t;
  typedef logic [1:0]         status_t;
  typedef logic [4:0]         count_t;
  typedef logic [1:0]         reg_index_t;

  // item modes
  localparam mode_t MODE_LOAD_A  = 2'd0;
  localparam mode_t MODE_LOAD_B  = 2'd1;
  localparam mode_t MODE_COMPUTE = 2'd2;

  // result status codes
  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_SIZE  = 2'd1;
  localparam status_t STATUS_INDEX = 2'd2;

  // configuration register indexes
  localparam reg_index_t REG_A_ROW_COUNT = 2'd0;
  localparam reg_index_t REG_A_COL_COUNT = 2'd1;
  localparam reg_index_t REG_B_ROW_COUNT = 2'd2;
  localparam reg_index_t REG_B_COL_COUNT = 2'd3;

  localparam count_t COUNT_RESET = 5'd16;

  // q15 arithmetic
  localparam int   Q_SHIFT = 15;
  localparam q15_t Q15_MAX = 16'sh7FFF;
  localparam q15_t Q15_MIN = -16'sh8000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/core/q15mm_cmd_if.sv =====
interface q15mm_cmd_if import q15mm_pkg::*; ();
  logic   valid;
  logic   ready;
  mode_t  mode;
  index_t row_index;
  index_t col_index;
  q15_t   element_value;

  modport source (output valid, mode, row_index, col_index, element_value, input ready);
  modport sink   (input valid, mode, row_index, col_index, element_value, output ready);
endinterface

// ===== rtl/core/q15mm_res_if.sv =====
interface q15mm_res_if import q15mm_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  q15_t    product_value;

  modport source (output valid, status, product_value, input ready);
  modport sink   (input valid, status, product_value, output ready);
endinterface

// ===== rtl/core/q15mm_ram.sv =====
module q15mm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/q15_matrix_multiply_core.sv =====
// Q15 matrix multiply core. Load items (mode 0 for A, mode 1 for B) write one
// signed 16-bit element into an on-chip store of MAX_DIM x MAX_DIM entries;
// loads outside MAX_DIM are dropped. A compute item (mode 2) names a row of A
// and a column of B and yields one result: the dot product over a_col_count
// terms (capped at MAX_DIM), floor-shifted right by 15 and saturated to 16
// bits, or status 1 (a_col_count != b_row_count) or 2 (index out of range)
// with a zero product. One shared 16x16 multiplier and accumulator walk the
// inner dimension one term per cycle, set by the single read port of each
// store. A compute issues the inner reads, then drains the store read, the
// multiplier register and the last accumulate, and then loads the output
// register. An error or empty inner dimension goes straight to the output
// register load. The core takes no new item while a compute is in flight,
// but it accepts items while a finished result waits in the output register.
// The user writes configuration through cfg_we/cfg_index/cfg_data only while
// the core is idle; the core itself does not enforce this. Mode 3 is ignored.
`include "assert_macros.svh"

module q15_matrix_multiply_core import q15mm_pkg::*; #(
  parameter int MAX_DIM = 16
) (
  input  logic          clk,
  input  logic          rst,
  q15mm_cmd_if.sink     cmd,
  q15mm_res_if.source   res,
  input  logic          cfg_we,
  input  reg_index_t    cfg_index,
  input  count_t        cfg_data
);

  // derived sizes
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int CMP_W  = (DIM_W > 5) ? DIM_W : 5;
  localparam int ACC_W  = 32 + $clog2(MAX_DIM);
  localparam int SH_W   = ACC_W - Q_SHIFT;

  // configuration registers
  count_t a_row_count;
  count_t a_col_count;
  count_t b_row_count;
  count_t b_col_count;

  // sequencer and datapath registers
  state_t                    state;
  state_t                    state_next;
  logic [DIM_W-1:0]          k;
  logic [DIM_W-1:0]          inner;
  logic [ADDR_W-1:0]         a_addr;
  logic [ADDR_W-1:0]         b_addr;
  logic                      rd_valid;
  logic                      mul_valid;
  logic signed [31:0]        prod;
  logic signed [ACC_W-1:0]   acc;
  status_t                   res_status;
  logic                      out_valid;
  status_t                   out_status;
  q15_t                      out_product;

  // control decode
  logic                      cmd_ready;
  logic                      cmd_xfer;
  logic                      issue;
  logic                      out_load;
  logic                      run_done;

  // compute checks
  logic [CMP_W-1:0]          row_w;
  logic [CMP_W-1:0]          col_w;
  logic [CMP_W-1:0]          lim_a_row;
  logic [CMP_W-1:0]          lim_a_col;
  logic [CMP_W-1:0]          lim_b_col;
  logic                      size_err;
  logic                      index_err;
  logic                      load_in_range;
  logic [ADDR_W-1:0]         load_addr;
  logic                      a_we;
  logic                      b_we;
  logic [15:0]               a_rdata;
  logic [15:0]               b_rdata;

  // result shaping
  logic signed [SH_W-1:0]    shifted;
  q15_t                      saturated;

  function automatic logic [CMP_W-1:0] clamp_dim(input count_t n);
    logic [CMP_W-1:0] v;
    v = CMP_W'(n);
    return (v > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM) : v;
  endfunction

  assign row_w     = CMP_W'(cmd.row_index);
  assign col_w     = CMP_W'(cmd.col_index);
  assign lim_a_row = clamp_dim(a_row_count);
  assign lim_a_col = clamp_dim(a_col_count);
  assign lim_b_col = clamp_dim(b_col_count);
  assign size_err  = (a_col_count != b_row_count);
  assign index_err = (row_w >= lim_a_row) || (col_w >= lim_b_col);

  // loads beyond the store are dropped
  assign load_in_range = (row_w < CMP_W'(MAX_DIM)) && (col_w < CMP_W'(MAX_DIM));
  assign load_addr     = ADDR_W'(ADDR_W'(cmd.row_index) * ADDR_W'(MAX_DIM)
                         + ADDR_W'(cmd.col_index));
  assign cmd_xfer      = cmd.valid && cmd_ready;
  assign a_we          = cmd_xfer && (cmd.mode == MODE_LOAD_A) && load_in_range;
  assign b_we          = cmd_xfer && (cmd.mode == MODE_LOAD_B) && load_in_range;

  // sequencer outputs
  always_comb begin
    cmd_ready = 1'b0;
    issue     = 1'b0;
    out_load  = 1'b0;
    run_done  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd_ready = 1'b1;
      end
      ST_RUN: begin
        issue    = (k != inner);
        run_done = (k == inner) && !rd_valid && !mul_valid;
      end
      ST_DONE: begin
        // hold the result until the output register frees up
        out_load = !out_valid || res.ready;
      end
      default: begin
      end
    endcase
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_xfer && (cmd.mode == MODE_COMPUTE)) begin
          if (size_err || index_err || (lim_a_col == '0)) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (run_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // element stores
  q15mm_ram #(
    .WIDTH(16),
    .DEPTH(DEPTH)
  ) u_a_store (
    .clk  (clk),
    .we   (a_we),
    .waddr(load_addr),
    .wdata(cmd.element_value),
    .re   (issue),
    .raddr(a_addr),
    .rdata(a_rdata)
  );

  q15mm_ram #(
    .WIDTH(16),
    .DEPTH(DEPTH)
  ) u_b_store (
    .clk  (clk),
    .we   (b_we),
    .waddr(load_addr),
    .wdata(cmd.element_value),
    .re   (issue),
    .raddr(b_addr),
    .rdata(b_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      rd_valid    <= 1'b0;
      mul_valid   <= 1'b0;
      out_valid   <= 1'b0;
      a_row_count <= COUNT_RESET;
      a_col_count <= COUNT_RESET;
      b_row_count <= COUNT_RESET;
      b_col_count <= COUNT_RESET;
    end else begin
      state     <= state_next;
      rd_valid  <= issue;
      mul_valid <= rd_valid;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_A_ROW_COUNT: a_row_count <= cfg_data;
          REG_A_COL_COUNT: a_col_count <= cfg_data;
          REG_B_ROW_COUNT: b_row_count <= cfg_data;
          REG_B_COL_COUNT: b_col_count <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // datapath: walk k over the inner dimension, one term per cycle
  always_ff @(posedge clk) begin
    if (cmd_xfer) begin
      k      <= '0;
      inner  <= DIM_W'(lim_a_col);
      // A walks along its row, B down its column
      a_addr <= ADDR_W'(ADDR_W'(cmd.row_index) * ADDR_W'(MAX_DIM));
      b_addr <= ADDR_W'(cmd.col_index);
      acc    <= '0;
      if (size_err) begin
        res_status <= STATUS_SIZE;
      end else if (index_err) begin
        res_status <= STATUS_INDEX;
      end else begin
        res_status <= STATUS_OK;
      end
    end else begin
      if (issue) begin
        k      <= k + 1'b1;
        a_addr <= a_addr + 1'b1;
        b_addr <= b_addr + ADDR_W'(MAX_DIM);
      end
      if (mul_valid) begin
        acc <= acc + ACC_W'(prod);
      end
    end
    // shared multiplier, registered before the accumulator
    prod <= signed'(a_rdata) * signed'(b_rdata);
    if (out_load) begin
      out_status  <= res_status;
      out_product <= (res_status == STATUS_OK) ? saturated : '0;
    end
  end

  // floor shift by 15 and saturate
  assign shifted = acc[ACC_W-1:Q_SHIFT];

  always_comb begin
    if (shifted > SH_W'(Q15_MAX)) begin
      saturated = Q15_MAX;
    end else if (shifted < SH_W'(Q15_MIN)) begin
      saturated = Q15_MIN;
    end else begin
      saturated = shifted[15:0];
    end
  end

  assign cmd.ready         = cmd_ready;
  assign res.valid         = out_valid;
  assign res.status        = out_status;
  assign res.product_value = out_product;

  // an error result never carries a product
  `ASSERT_IMPLY(a_err_zero, clk, rst, res.valid && (res.status != STATUS_OK), res.product_value == '0)
  // no term is in flight once the sequencer is back to idle
  `ASSERT_IMPLY(a_idle_drained, clk, rst, state == ST_IDLE, !rd_valid && !mul_valid)
  // a finished result waits while the output register is still occupied
  `ASSERT_NEXT(a_done_holds, clk, rst, (state == ST_DONE) && out_valid && !res.ready, state == ST_DONE)

endmodule
